### hw/rtl/ibl_pkg.sv
// ibl_pkg: shared types and constants of the imu bias / low-pass / deadband filter
// no dependencies
package ibl_pkg;

  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 40;

  typedef enum logic [CfgIdxW-1:0] {
    RegGyroLimit    = 3'd0,
    RegAccelLimit   = 3'd1,
    RegGravityRef   = 3'd2,
    RegStillGyroMax = 3'd3,
    RegStillAccDev  = 3'd4,
    RegStillWindow  = 3'd5,
    RegGyroRc       = 3'd6,
    RegAccelRc      = 3'd7
  } cfg_reg_e;

  // shared unit operations
  typedef enum logic [1:0] {
    OpSquare = 2'd0,
    OpDivS   = 2'd1,
    OpDivU   = 2'd2
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage

### hw/rtl/ibl_alu.sv
// ibl_alu: shared multi-cycle unit: 32x32 square, signed and unsigned shift-subtract divide
// depends on ibl_pkg
module ibl_alu (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ibl_pkg::alu_ctl_t     ctl_i,
  input  logic [63:0]           a_i,
  input  logic [63:0]           b_i,
  input  logic [6:0]            steps_i,
  output ibl_pkg::alu_sts_t     sts_o,
  output logic [63:0]           res_o
);
  import ibl_pkg::*;

  logic        busy_q, done_q, neg_q;
  alu_op_e     op_q;
  logic [6:0]  cnt_q;
  logic [64:0] rem_q;
  logic [63:0] quo_q, dvs_q, res_q;
  logic [31:0] sq_a_q;
  logic [64:0] rem_sh;
  logic [63:0] abs_a, abs_b;

  assign abs_a = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign abs_b = b_i[63] ? (~b_i + 64'd1) : b_i;
  assign rem_sh = {rem_q[63:0], quo_q[63]};

  // iterate one quotient bit a cycle; a square is computed from the captured operand
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OpSquare;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        op_q <= ctl_i.op;
        unique case (ctl_i.op)
          OpSquare: begin
            sq_a_q <= abs_a[31:0];
            busy_q <= 1'b1;
            cnt_q  <= 7'd0;
          end
          OpDivS: begin
            quo_q  <= abs_a;
            dvs_q  <= abs_b;
            neg_q  <= a_i[63] ^ b_i[63];
            rem_q  <= '0;
            cnt_q  <= steps_i;
            busy_q <= 1'b1;
          end
          default: begin
            // fractional divide: a < b starts as the remainder, zeros shift in
            quo_q  <= '0;
            dvs_q  <= b_i;
            neg_q  <= 1'b0;
            rem_q  <= {1'b0, a_i};
            cnt_q  <= steps_i;
            busy_q <= 1'b1;
          end
        endcase
      end else if (busy_q) begin
        if (op_q == OpSquare) begin
          res_q  <= 64'(sq_a_q) * 64'(sq_a_q);
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else if (cnt_q == 7'd0) begin
          res_q  <= neg_q ? (~quo_q + 64'd1) : quo_q;
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 7'd1;
          if (rem_sh >= {1'b0, dvs_q}) begin
            rem_q <= rem_sh - {1'b0, dvs_q};
            quo_q <= {quo_q[62:0], 1'b1};
          end else begin
            rem_q <= rem_sh;
            quo_q <= {quo_q[62:0], 1'b0};
          end
        end
      end
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign res_o = res_q;

endmodule

### hw/rtl/imu_bias_lpf_deadband_filter_core.sv
// imu_bias_lpf_deadband_filter_core: top level, sequencer and filter state
// depends on ibl_pkg and ibl_alu
//
// Usage: one imu sample beat enters on in_valid_i/in_ready_o; one result beat
// leaves on out_valid_o/out_ready_i for every sample. Configuration registers
// are to be written through cfg_we_i/cfg_idx_i/cfg_data_i while the block is
// idle; the block itself does not enforce it. A sample runs through a
// sequencer that drives one shared unit: nine squares for the stillness test,
// up to six signed 64-step divides for the running mean and one 16-step divide
// for each filtered component alpha; the low-pass products use a separate
// multiplier in the sequencer. A rejected sample gets its result beat from
// StCheck; an accepted one gets it from StOut after the squares, the bias
// divides while the window is open, and the alpha divide and low-pass steps of
// each filter that is not bypassed. in_ready_o is low from acceptance until the
// result beat is taken. The result register holds while out_ready_i is low.
// Reset clears the filter state, the bias window and the registers to their
// reset values; no clearing pass is needed.
module imu_bias_lpf_deadband_filter_core #(
  parameter int unsigned EULER_LIMIT    = 0,
  parameter int unsigned GYRO_DEADBAND  = 0,
  parameter int unsigned ACCEL_DEADBAND = 0,
  parameter int unsigned FRAC_BITS      = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ibl_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ibl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [62:0]                   timestamp_ns_i,
  input  logic signed [31:0]            gyro_x_i,
  input  logic signed [31:0]            gyro_y_i,
  input  logic signed [31:0]            gyro_z_i,
  input  logic signed [31:0]            accel_x_i,
  input  logic signed [31:0]            accel_y_i,
  input  logic signed [31:0]            accel_z_i,
  input  logic signed [31:0]            euler_x_i,
  input  logic signed [31:0]            euler_y_i,
  input  logic signed [31:0]            euler_z_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          accepted_o,
  output logic signed [31:0]            filtered_gyro_x_o,
  output logic signed [31:0]            filtered_gyro_y_o,
  output logic signed [31:0]            filtered_gyro_z_o,
  output logic signed [31:0]            filtered_accel_x_o,
  output logic signed [31:0]            filtered_accel_y_o,
  output logic signed [31:0]            filtered_accel_z_o,
  output logic                          bias_locked_o,
  output logic                          still_now_o
);
  import ibl_pkg::*;

  localparam logic [39:0] Max40 = {40{1'b1}};
  localparam logic [31:0] Max32 = {32{1'b1}};
  localparam logic [6:0]  AlphaSteps = 7'(FRAC_BITS);

  typedef enum logic [3:0] {
    StIdle, StCheck, StSqGo, StSqWait, StStill, StBiasGo, StBiasWait,
    StCorr, StAlphaGo, StAlphaWait, StMul, StLpf, StOut
  } state_e;

  // configuration
  logic [30:0] gyro_limit_q, accel_limit_q, gravity_ref_q, still_gyro_max_q, still_dev_q;
  logic [39:0] still_window_q;
  logic [31:0] gyro_rc_q, accel_rc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_limit_q     <= '0;
      accel_limit_q    <= '0;
      gravity_ref_q    <= 31'd642690;
      still_gyro_max_q <= 31'd1311;
      still_dev_q      <= 31'd13107;
      still_window_q   <= 40'd1000000000;
      gyro_rc_q        <= '0;
      accel_rc_q       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        RegGyroLimit:    gyro_limit_q     <= cfg_data_i[30:0];
        RegAccelLimit:   accel_limit_q    <= cfg_data_i[30:0];
        RegGravityRef:   gravity_ref_q    <= cfg_data_i[30:0];
        RegStillGyroMax: still_gyro_max_q <= cfg_data_i[30:0];
        RegStillAccDev:  still_dev_q      <= cfg_data_i[30:0];
        RegStillWindow:  still_window_q   <= cfg_data_i[39:0];
        RegGyroRc:       gyro_rc_q        <= cfg_data_i[31:0];
        default:         accel_rc_q       <= cfg_data_i[31:0];
      endcase
    end
  end

  // sample and state storage; index 0..2 gyro, 3..5 accel
  state_e             state_q;
  logic [62:0]        ts_q, prev_time_q, dt_q;
  logic signed [31:0] smp_q [6];
  logic signed [31:0] eul_q [3];
  logic signed [31:0] bias_q [6];
  logic signed [31:0] smooth_q [6];
  logic signed [31:0] corr_q [6];
  logic [39:0]        win_time_q;
  logic [31:0]        win_cnt_q;
  logic               bias_done_q, still_flag_q;
  logic [3:0]         idx_q;
  logic [65:0]        gsum_q, asum_q, gmax_q, lo_q, hi_q;
  logic [FRAC_BITS-1:0] alpha_q;
  logic signed [63:0] prod_q;
  logic               out_valid_q, acc_q;
  logic signed [31:0] res_q [6];

  // shared unit
  alu_ctl_t    alu_ctl;
  alu_sts_t    alu_sts;
  logic [63:0] alu_a, alu_b, alu_res;
  logic [6:0]  alu_steps;

  ibl_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (alu_ctl),
    .a_i     (alu_a),
    .b_i     (alu_b),
    .steps_i (alu_steps),
    .sts_o   (alu_sts),
    .res_o   (alu_res)
  );

  // limit checks, combinational on captured sample
  function automatic logic over_lim(input logic signed [31:0] v, input logic [30:0] lim);
    logic [32:0] av;
    av = v[31] ? (33'd0 - 33'(signed'(v))) : 33'(v);
    return (lim != '0) && (av > 33'(lim));
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic reject;
  always_comb begin
    reject = 1'b0;
    for (int i = 0; i < 3; i++) begin
      reject |= over_lim(smp_q[i], gyro_limit_q);
      reject |= over_lim(smp_q[i+3], accel_limit_q);
      reject |= over_lim(eul_q[i], 31'(EULER_LIMIT));
    end
  end

  logic [2:0] ci;
  logic       is_acc;
  logic [31:0] rc_sel;
  logic signed [32:0] diff;
  assign ci     = idx_q[2:0];
  assign is_acc = (ci >= 3'd3);
  assign rc_sel = is_acc ? accel_rc_q : gyro_rc_q;
  assign diff   = 33'(smp_q[ci]) - 33'(bias_q[ci]);

  logic [62:0] dt_new;
  assign dt_new = ((prev_time_q != '0) && (ts_q > prev_time_q)) ? ts_q - prev_time_q : '0;

  logic [63:0] win_sum;
  assign win_sum = 64'(win_time_q) + 64'(dt_q);

  logic [31:0] lo_b, hi_b;
  assign hi_b = 32'(gravity_ref_q) + 32'(still_dev_q);
  assign lo_b = (gravity_ref_q > still_dev_q) ? 32'(gravity_ref_q - still_dev_q) : '0;

  // shared unit operand mux
  always_comb begin
    alu_ctl.start = 1'b0;
    alu_ctl.op    = OpSquare;
    alu_a         = '0;
    alu_b         = '0;
    alu_steps     = 7'd64;
    unique case (state_q)
      StSqGo: begin
        alu_ctl.start = 1'b1;
        priority case (1'b1)
          (idx_q < 4'd6): alu_a = 64'(signed'(smp_q[ci]));
          (idx_q == 4'd6): alu_a = 64'(still_gyro_max_q);
          (idx_q == 4'd7): alu_a = 64'(lo_b);
          default: alu_a = 64'(hi_b);
        endcase
      end
      StBiasGo: begin
        alu_ctl.start = 1'b1;
        alu_ctl.op    = OpDivS;
        alu_a         = 64'(signed'(diff));
        alu_b         = 64'(win_cnt_q);
      end
      StAlphaGo: begin
        // bypassed components leave the unit idle
        alu_ctl.start = (rc_sel != '0) && (dt_q != '0);
        alu_ctl.op    = OpDivU;
        alu_a         = 64'(dt_q);
        alu_b         = 64'(dt_q) + 64'(rc_sel);
        alu_steps     = AlphaSteps;
      end
      default: ;
    endcase
  end

  logic signed [32:0] lp_diff;
  logic signed [63:0] lp_q;
  assign lp_diff = 33'(corr_q[ci]) - 33'(smooth_q[ci]);
  // truncating division of the product by 2^FRAC_BITS
  assign lp_q = (prod_q < 0) ? -((-prod_q) >>> FRAC_BITS) : (prod_q >>> FRAC_BITS);

  function automatic logic signed [31:0] dband(input logic signed [31:0] v,
                                               input logic [30:0] th);
    logic [32:0] av;
    av = v[31] ? (33'd0 - 33'(signed'(v))) : 33'(v);
    return ((th != '0) && (av < 33'(th))) ? 32'sd0 : v;
  endfunction

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      prev_time_q  <= '0;
      win_time_q   <= '0;
      win_cnt_q    <= '0;
      bias_done_q  <= 1'b0;
      still_flag_q <= 1'b0;
      out_valid_q  <= 1'b0;
      idx_q        <= '0;
      for (int i = 0; i < 6; i++) begin
        bias_q[i]   <= '0;
        smooth_q[i] <= '0;
      end
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (in_valid_i && !out_valid_q) begin
            ts_q     <= timestamp_ns_i;
            smp_q[0] <= gyro_x_i;  smp_q[1] <= gyro_y_i;  smp_q[2] <= gyro_z_i;
            smp_q[3] <= accel_x_i; smp_q[4] <= accel_y_i; smp_q[5] <= accel_z_i;
            eul_q[0] <= euler_x_i; eul_q[1] <= euler_y_i; eul_q[2] <= euler_z_i;
            state_q  <= StCheck;
          end
        end
        StCheck: begin
          if (reject) begin
            acc_q        <= 1'b0;
            out_valid_q  <= 1'b1;
            for (int i = 0; i < 6; i++) res_q[i] <= '0;
            state_q      <= StIdle;
          end else begin
            dt_q        <= dt_new;
            prev_time_q <= ts_q;
            gsum_q      <= '0;
            asum_q      <= '0;
            idx_q       <= '0;
            state_q     <= StSqGo;
          end
        end
        StSqGo: state_q <= StSqWait;
        StSqWait: begin
          if (alu_sts.done) begin
            priority case (1'b1)
              (idx_q < 4'd3): gsum_q <= gsum_q + 66'(alu_res);
              (idx_q < 4'd6): asum_q <= asum_q + 66'(alu_res);
              (idx_q == 4'd6): gmax_q <= 66'(alu_res);
              (idx_q == 4'd7): lo_q <= 66'(alu_res);
              default: hi_q <= 66'(alu_res);
            endcase
            if (idx_q == 4'd8) begin
              state_q <= StStill;
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= StSqGo;
            end
          end
        end
        StStill: begin
          // sums fold to 64 bits like the modulo arithmetic of the squares
          state_q <= StBiasGo;
          idx_q   <= '0;
          if (!bias_done_q) begin
            if ((gsum_q[63:0] <= gmax_q[63:0]) && (asum_q[63:0] >= lo_q[63:0]) &&
                (asum_q[63:0] <= hi_q[63:0]) && (dt_q != '0)) begin
              still_flag_q <= 1'b1;
              win_time_q   <= (win_sum >= 64'(Max40)) ? Max40 : win_sum[39:0];
              if (win_cnt_q != Max32) win_cnt_q <= win_cnt_q + 32'd1;
            end else begin
              still_flag_q <= 1'b0;
              win_time_q   <= '0;
              win_cnt_q    <= '0;
              for (int i = 0; i < 6; i++) bias_q[i] <= '0;
              state_q <= StCorr;
            end
          end else begin
            still_flag_q <= (gsum_q[63:0] <= gmax_q[63:0]) &&
                            (asum_q[63:0] >= lo_q[63:0]) && (asum_q[63:0] <= hi_q[63:0]);
            state_q      <= StCorr;
          end
        end
        StBiasGo: state_q <= StBiasWait;
        StBiasWait: begin
          if (alu_sts.done) begin
            bias_q[ci] <= sat32(34'(bias_q[ci]) + 34'(signed'(alu_res[32:0])));
            if (idx_q == 4'd5) begin
              if (win_time_q >= still_window_q) bias_done_q <= 1'b1;
              state_q <= StCorr;
            end else begin
              idx_q   <= idx_q + 4'd1;
              state_q <= StBiasGo;
            end
          end
        end
        StCorr: begin
          for (int i = 0; i < 6; i++)
            corr_q[i] <= sat32(34'(smp_q[i]) - 34'(bias_q[i]));
          idx_q   <= '0;
          state_q <= StAlphaGo;
        end
        StAlphaGo: begin
          if ((rc_sel == '0) || (dt_q == '0)) begin
            smooth_q[ci] <= corr_q[ci];
            if (idx_q == 4'd5) state_q <= StOut;
            else idx_q <= idx_q + 4'd1;
          end else begin
            state_q <= StAlphaWait;
          end
        end
        StAlphaWait: begin
          if (alu_sts.done) begin
            alpha_q <= alu_res[FRAC_BITS-1:0];
            state_q <= StMul;
          end
        end
        StMul: begin
          prod_q  <= 64'(signed'({1'b0, alpha_q})) * 64'(lp_diff);
          state_q <= StLpf;
        end
        StLpf: begin
          smooth_q[ci] <= sat32(34'(smooth_q[ci]) + 34'(lp_q));
          if (idx_q == 4'd5) begin
            state_q <= StOut;
          end else begin
            idx_q   <= idx_q + 4'd1;
            state_q <= StAlphaGo;
          end
        end
        default: begin
          acc_q       <= 1'b1;
          out_valid_q <= 1'b1;
          for (int i = 0; i < 3; i++) begin
            res_q[i]   <= dband(smooth_q[i], 31'(GYRO_DEADBAND));
            res_q[i+3] <= dband(smooth_q[i+3], 31'(ACCEL_DEADBAND));
          end
          state_q <= StIdle;
        end
      endcase
    end
  end

  assign in_ready_o         = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o        = out_valid_q;
  assign accepted_o         = acc_q;
  assign filtered_gyro_x_o  = res_q[0];
  assign filtered_gyro_y_o  = res_q[1];
  assign filtered_gyro_z_o  = res_q[2];
  assign filtered_accel_x_o = res_q[3];
  assign filtered_accel_y_o = res_q[4];
  assign filtered_accel_z_o = res_q[5];
  assign bias_locked_o      = acc_q & bias_done_q;
  assign still_now_o        = acc_q & still_flag_q;

  // no new sample while a result beat is pending
  a_no_accept_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  // the shared unit is only started from the sequencer when it is free
  a_alu_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_ctl.start |-> !alu_sts.busy) else $error("shared unit restarted while busy");
  // a rejected beat carries no status
  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !accepted_o) |-> (!bias_locked_o && !still_now_o))
    else $error("rejected beat with status");

endmodule

### sim/tb_imu_bias_lpf_deadband_filter_core.sv
`timescale 1ns / 1ps
// tb_imu_bias_lpf_deadband_filter_core: self-checking bench for the imu bias / low-pass filter
// depends on ibl_pkg and imu_bias_lpf_deadband_filter_core; a scoreboard class predicts each beat

module tb_imu_bias_lpf_deadband_filter_core;
  import ibl_pkg::*;

  localparam int unsigned FracBits      = 16;
  localparam int unsigned EulerLimit    = 0;
  localparam int unsigned GyroDeadband  = 0;
  localparam int unsigned AccelDeadband = 0;
  localparam bit [63:0] Mask31 = 64'h7FFF_FFFF;
  localparam bit [63:0] Mask32 = 64'hFFFF_FFFF;
  localparam bit [63:0] Mask40 = 64'hFF_FFFF_FFFF;
  localparam int CycleLimit = 6000000;
  localparam int TailCycles = 600;
  localparam int HoldCycles = 3000;
  localparam int PhaseItems = 210;

  typedef struct {
    logic [62:0]        ts;
    logic signed [31:0] gyro[3];
    logic signed [31:0] accel[3];
    logic signed [31:0] euler[3];
  } imu_sample_t;

  typedef struct {
    logic               acc;
    logic signed [31:0] fgyro[3];
    logic signed [31:0] faccel[3];
    logic               ready;
    logic               still;
  } filt_result_t;

  // predictor of the filter plus queue of expected result beats
  class filter_scoreboard;
    bit [63:0] gyro_limit, accel_limit, gravity_ref, still_gyro_max;
    bit [63:0] still_dev_max, still_window, gyro_rc, accel_rc;
    bit [63:0] prev_time, win_time, win_count;
    longint    gyro_off[3], accel_off[3], gyro_smooth[3], accel_smooth[3];
    bit        bias_done, still_flag;
    filt_result_t expected_q[$];
    int        errors;

    function new();
      int i;
      gyro_limit = 0; accel_limit = 0; gravity_ref = 642690;
      still_gyro_max = 1311; still_dev_max = 13107;
      still_window = 64'd1000000000; gyro_rc = 0; accel_rc = 0;
      prev_time = 0; win_time = 0; win_count = 0;
      for (i = 0; i < 3; i++) begin
        gyro_off[i] = 0; accel_off[i] = 0; gyro_smooth[i] = 0; accel_smooth[i] = 0;
      end
      bias_done = 0; still_flag = 0; errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, bit [63:0] val);
      case (idx)
        RegGyroLimit:    gyro_limit = val & Mask31;
        RegAccelLimit:   accel_limit = val & Mask31;
        RegGravityRef:   gravity_ref = val & Mask31;
        RegStillGyroMax: still_gyro_max = val & Mask31;
        RegStillAccDev:  still_dev_max = val & Mask31;
        RegStillWindow:  still_window = val & Mask40;
        RegGyroRc:       gyro_rc = val & Mask32;
        RegAccelRc:      accel_rc = val & Mask32;
        default: ;
      endcase
    endfunction

    function bit [63:0] abs_u(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function longint sat32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function bit exceeds(longint v[3], bit [63:0] lim);
      int i;
      if (lim == 0) return 0;
      for (i = 0; i < 3; i++) if (abs_u(v[i]) > lim) return 1;
      return 0;
    endfunction

    function bit [63:0] sq_norm(longint v[3]);
      bit [63:0] s;
      int i;
      s = 0;
      for (i = 0; i < 3; i++) s = s + abs_u(v[i]) * abs_u(v[i]);
      return s;
    endfunction

    // bit-serial alpha = floor(dt * 2^FracBits / (rc + dt))
    function bit [63:0] alpha_q(bit [63:0] dt, bit [63:0] rc);
      bit [63:0] d, r, q;
      bit carry;
      int i;
      d = dt + rc; r = dt; q = 0;
      for (i = 0; i < FracBits; i++) begin
        carry = r[63];
        r = r << 1;
        q = q << 1;
        if (carry || r >= d) begin
          r = r - d;
          q[0] = 1'b1;
        end
      end
      return q;
    endfunction

    function longint lp_next(longint sm, longint corr, bit [63:0] rc, bit [63:0] dt);
      longint a, p;
      if (rc == 0 || dt == 0) return corr;
      a = longint'(alpha_q(dt, rc));
      p = a * (corr - sm);
      return sat32(sm + p / (longint'(1) << FracBits));
    endfunction

    function longint dead(longint v, bit [63:0] th);
      if (th != 0 && abs_u(v) < th) return 0;
      return v;
    endfunction

    function void note_sample(imu_sample_t s);
      longint g[3], a[3], e[3];
      bit [63:0] t, dt, gmax, an, hi, lo;
      bit still;
      longint n;
      filt_result_t r;
      int i;
      r.acc = 0; r.ready = 0; r.still = 0;
      for (i = 0; i < 3; i++) begin
        g[i] = s.gyro[i]; a[i] = s.accel[i]; e[i] = s.euler[i];
        r.fgyro[i] = 0; r.faccel[i] = 0;
      end
      // rejected beat leaves state untouched
      if (exceeds(g, gyro_limit) || exceeds(a, accel_limit) || exceeds(e, EulerLimit)) begin
        expected_q.push_back(r);
        return;
      end
      t = 64'(s.ts);
      dt = 0;
      if (prev_time > 0 && t > prev_time) dt = t - prev_time;
      prev_time = t;
      // stillness on squared norms
      gmax = still_gyro_max * still_gyro_max;
      an = sq_norm(a);
      hi = gravity_ref + still_dev_max;
      lo = (gravity_ref > still_dev_max) ? gravity_ref - still_dev_max : 0;
      still = sq_norm(g) <= gmax && an >= lo * lo && an <= hi * hi;
      // running-mean bias window
      if (!bias_done) begin
        if (still && dt > 0) begin
          still_flag = 1;
          win_time = (dt >= Mask40 - win_time) ? Mask40 : win_time + dt;
          if (win_count < Mask32) win_count++;
          n = longint'(win_count);
          for (i = 0; i < 3; i++) begin
            gyro_off[i] = sat32(gyro_off[i] + (g[i] - gyro_off[i]) / n);
            accel_off[i] = sat32(accel_off[i] + (a[i] - accel_off[i]) / n);
          end
          if (win_time >= still_window) bias_done = 1;
        end else begin
          still_flag = 0; win_time = 0; win_count = 0;
          for (i = 0; i < 3; i++) begin
            gyro_off[i] = 0; accel_off[i] = 0;
          end
        end
      end else begin
        still_flag = still;
      end
      // correction, low-pass, deadband
      for (i = 0; i < 3; i++) begin
        gyro_smooth[i] = lp_next(gyro_smooth[i], sat32(g[i] - gyro_off[i]), gyro_rc, dt);
        accel_smooth[i] = lp_next(accel_smooth[i], sat32(a[i] - accel_off[i]), accel_rc, dt);
        r.fgyro[i] = 32'(dead(gyro_smooth[i], GyroDeadband));
        r.faccel[i] = 32'(dead(accel_smooth[i], AccelDeadband));
      end
      r.acc = 1; r.ready = bias_done; r.still = still_flag;
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(filt_result_t got);
      filt_result_t w;
      int i;
      if (expected_q.size() == 0) begin
        report("result beat with no sample pending");
        return;
      end
      w = expected_q.pop_front();
      if (got.acc !== w.acc) report($sformatf("accepted %0b exp %0b", got.acc, w.acc));
      for (i = 0; i < 3; i++) begin
        if (got.fgyro[i] !== w.fgyro[i])
          report($sformatf("gyro[%0d] %0d exp %0d", i, got.fgyro[i], w.fgyro[i]));
        if (got.faccel[i] !== w.faccel[i])
          report($sformatf("accel[%0d] %0d exp %0d", i, got.faccel[i], w.faccel[i]));
      end
      if (got.ready !== w.ready) report($sformatf("bias_locked %0b exp %0b", got.ready, w.ready));
      if (got.still !== w.still) report($sformatf("still_now %0b exp %0b", got.still, w.still));
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic in_valid_i, in_ready_o, out_valid_o, out_ready_i;
  logic [62:0] timestamp_ns_i;
  logic signed [31:0] gyro_x_i, gyro_y_i, gyro_z_i, accel_x_i, accel_y_i, accel_z_i;
  logic signed [31:0] euler_x_i, euler_y_i, euler_z_i;
  logic accepted_o, bias_locked_o, still_now_o;
  logic signed [31:0] filtered_gyro_x_o, filtered_gyro_y_o, filtered_gyro_z_o;
  logic signed [31:0] filtered_accel_x_o, filtered_accel_y_o, filtered_accel_z_o;

  filter_scoreboard sb = new();
  bit [62:0] ts_now;
  bit hold_req;
  int hold_left, stall_left, calm_left;
  int cycles;

  imu_bias_lpf_deadband_filter_core DUT (.*);

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stalls, calm stretches and the long hold-off
  initial begin
    out_ready_i = 1'b0;
    hold_left = 0; stall_left = 0; calm_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_left = HoldCycles;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if (calm_left > 0) calm_left--;
        else begin
          case ($urandom_range(0, 99)) inside
            [0:2]:   calm_left = $urandom_range(200, 2000);
            [3:7]:   stall_left = $urandom_range(20, 80);
            [8:29]:  stall_left = $urandom_range(1, 4);
            default: ;
          endcase
        end
      end
    end
  end

  // result beat check
  always @(posedge clk_i) begin
    filt_result_t r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      r.acc = accepted_o;
      r.fgyro[0] = filtered_gyro_x_o; r.fgyro[1] = filtered_gyro_y_o;
      r.fgyro[2] = filtered_gyro_z_o;
      r.faccel[0] = filtered_accel_x_o; r.faccel[1] = filtered_accel_y_o;
      r.faccel[2] = filtered_accel_z_o;
      r.ready = bias_locked_o; r.still = still_now_o;
      sb.check_result(r);
    end
  end

  task send_sample(imu_sample_t s);
    @(negedge clk_i);
    timestamp_ns_i = s.ts;
    gyro_x_i = s.gyro[0]; gyro_y_i = s.gyro[1]; gyro_z_i = s.gyro[2];
    accel_x_i = s.accel[0]; accel_y_i = s.accel[1]; accel_z_i = s.accel[2];
    euler_x_i = s.euler[0]; euler_y_i = s.euler[1]; euler_z_i = s.euler[2];
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_sample(s);
  endtask

  task sender_gap();
    int k, n;
    k = $urandom_range(0, 99);
    if (k < 55) return;
    n = (k < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  // stop offering and wait for every pending result
  task drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task write_reg(cfg_reg_e idx, bit [63:0] v);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = v[CfgDataW-1:0];
    sb.set_reg(idx, v & Mask40);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  function imu_sample_t flat(bit [62:0] ts, logic signed [31:0] gv, logic signed [31:0] av);
    imu_sample_t s;
    int i;
    s.ts = ts;
    for (i = 0; i < 3; i++) begin
      s.gyro[i] = gv; s.accel[i] = av; s.euler[i] = $urandom;
    end
    return s;
  endfunction

  // sample near rest on the current gravity reference
  function imu_sample_t still_sample(bit [62:0] ts);
    imu_sample_t s;
    longint z;
    int i;
    s.ts = ts;
    for (i = 0; i < 3; i++) begin
      s.gyro[i] = int'($urandom_range(0, 1400)) - 700;
      s.euler[i] = $urandom;
    end
    s.accel[0] = int'($urandom_range(0, 6000)) - 3000;
    s.accel[1] = int'($urandom_range(0, 6000)) - 3000;
    z = longint'(sb.gravity_ref) + (int'($urandom_range(0, 8000)) - 4000);
    if (z > 64'sd2147483647) z = 64'sd2147483647;
    if ($urandom_range(0, 1)) z = -z;
    s.accel[2] = 32'(z);
    return s;
  endfunction

  function imu_sample_t noise_sample(bit [62:0] ts, bit wide);
    imu_sample_t s;
    int i;
    s.ts = ts;
    for (i = 0; i < 3; i++) begin
      s.gyro[i] = wide ? $urandom : int'($urandom_range(0, 10000)) - 5000;
      s.accel[i] = wide ? $urandom : int'($urandom_range(0, 1400000)) - 700000;
      s.euler[i] = $urandom;
    end
    return s;
  endfunction

  function bit [63:0] pick(bit [63:0] mask, bit [63:0] dflt, int unsigned lo, int unsigned hi);
    case ($urandom_range(0, 19)) inside
      [0:2]:   return 0;
      [3:5]:   return mask;
      [6:7]:   return {$urandom, $urandom} & Mask40;
      [8:10]:  return dflt;
      default: return 64'($urandom_range(lo, hi));
    endcase
  endfunction

  task configure(int ph);
    case (ph)
      0: begin
        write_reg(RegGyroLimit, Mask31); write_reg(RegAccelLimit, Mask31);
        write_reg(RegGravityRef, Mask31); write_reg(RegStillGyroMax, Mask31);
        write_reg(RegStillAccDev, Mask31); write_reg(RegStillWindow, Mask40);
        write_reg(RegGyroRc, Mask32); write_reg(RegAccelRc, Mask32);
      end
      1: begin
        write_reg(RegGyroLimit, 0); write_reg(RegAccelLimit, 0);
        write_reg(RegGravityRef, 0); write_reg(RegStillGyroMax, 0);
        write_reg(RegStillAccDev, 0); write_reg(RegStillWindow, 0);
        write_reg(RegGyroRc, 0); write_reg(RegAccelRc, 0);
      end
      default: begin
        write_reg(RegGyroLimit, pick(Mask31, 0, 2000000, 2000000000));
        write_reg(RegAccelLimit, pick(Mask31, 0, 2000000, 2000000000));
        write_reg(RegGravityRef, ($urandom_range(0, 3) != 0) ? 64'd642690 :
                                  pick(Mask31, 642690, 100000, 2000000));
        write_reg(RegStillGyroMax, pick(Mask31, 1311, 800, 5000));
        write_reg(RegStillAccDev, pick(Mask31, 13107, 5000, 50000));
        write_reg(RegStillWindow, ($urandom_range(0, 3) == 0) ?
                                  pick(Mask40, 1000000000, 0, 0) :
                                  64'($urandom_range(10000000, 300000000)));
        write_reg(RegGyroRc, pick(Mask32, 0, 100000, 100000000));
        write_reg(RegAccelRc, pick(Mask32, 0, 100000, 100000000));
      end
    endcase
  endtask

  // stimulus
  initial begin
    imu_sample_t s;
    int still_left, k, i;
    bit [62:0] ts;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0; cfg_idx_i = RegGyroLimit; cfg_data_i = '0;
    in_valid_i = 1'b0; timestamp_ns_i = '0;
    gyro_x_i = '0; gyro_y_i = '0; gyro_z_i = '0;
    accel_x_i = '0; accel_y_i = '0; accel_z_i = '0;
    euler_x_i = '0; euler_y_i = '0; euler_z_i = '0;
    hold_req = 0; cycles = 0; still_left = 0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: zero time, dt of zero, backward time, extremes, top of time range
    send_sample(flat(0, 0, 0));
    send_sample(still_sample(63'd10000000));
    send_sample(still_sample(63'd20000000));
    send_sample(still_sample(63'd20000000));
    send_sample(still_sample(63'd5000000));
    send_sample(flat(63'd30000000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    send_sample(flat(63'd40000000, 32'sh8000_0000, 32'sh8000_0000));
    send_sample(still_sample('1));
    drain();

    // directed: limits on, zero window, gyro filter at a mid rc, accel filter at the largest rc
    write_reg(RegGyroLimit, 1000);
    write_reg(RegAccelLimit, 700000);
    write_reg(RegStillWindow, 0);
    write_reg(RegGyroRc, 1000000);
    write_reg(RegAccelRc, Mask32);
    ts_now = 63'd1000;
    send_sample(flat(ts_now, 32'sh8000_0000, 0));
    send_sample(flat(ts_now, 1000, 0));
    send_sample(flat(ts_now, 1001, 0));
    send_sample(flat(ts_now, 0, 700001));
    send_sample(flat(ts_now, -1000, -700000));
    for (i = 0; i < 6; i++) begin
      ts_now += 63'd2000000;
      send_sample(still_sample(ts_now));
    end
    drain();

    // random phases of still runs with noise mixed in
    for (int ph = 0; ph < 8; ph++) begin
      configure(ph);
      for (int n = 0; n < PhaseItems; n++) begin
        k = $urandom_range(0, 99);
        if (k < 3) ts = ts_now;
        else if (k < 5) ts = ts_now - 63'($urandom_range(1, 50000000));
        else if (k < 6) begin
          ts_now = 63'({$urandom, $urandom} >> 2);
          ts = ts_now;
        end else begin
          ts_now += 63'($urandom_range(100000, 20000000));
          ts = ts_now;
        end
        if (still_left > 0) begin
          s = still_sample(ts);
          still_left--;
        end else begin
          k = $urandom_range(0, 99);
          if (k < 70) begin
            still_left = $urandom_range(3, 40);
            s = still_sample(ts);
          end else if (k < 85) s = noise_sample(ts, 0);
          else begin
            s = noise_sample(ts, 1);
            if ($urandom_range(0, 1)) s.ts = 63'({$urandom, $urandom});
          end
        end
        send_sample(s);
        if (ph == 3 && n == 40) hold_req = 1;
        if (ph == 4 && n == 100) drain();
        else sender_gap();
      end
      drain();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/ibl_pkg.sv
hw/rtl/ibl_alu.sv
hw/rtl/imu_bias_lpf_deadband_filter_core.sv
sim/tb_imu_bias_lpf_deadband_filter_core.sv
